[hdl/sst_pkg.sv]
`timescale 1ns / 1ps

package sst_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int NAME_W      = 64;
    localparam int SCOPE_W     = 8;
    localparam int TOTAL_W     = 16;

    localparam logic [SCOPE_W-1:0] SCOPE_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [2:0] {
        ACT_ADD           = 3'd0,
        ACT_LOOKUP        = 3'd1,
        ACT_ENTER         = 3'd2,
        ACT_LEAVE         = 3'd3,
        ACT_TEMP_ADD      = 3'd4,
        ACT_TEMP_FREE     = 3'd5,
        ACT_TEMP_FREE_ALL = 3'd6,
        ACT_TEMP_QUERY    = 3'd7
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [NAME_W-1:0] name_key;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         address;
        logic [SCOPE_W-1:0] scope_level;
        logic [NAME_W-1:0]  removed_name;
        logic [6:0]         symbol_count;
        logic [6:0]         temp_count;
        logic [TOTAL_W-1:0] temps_created;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_LATCH    = 4'd1,
        DP_SINGLE   = 4'd2,
        DP_TEMP_RD  = 4'd3,
        DP_TEMP_FIN = 4'd4,
        DP_LK_START = 4'd5,
        DP_LK_STEP  = 4'd6,
        DP_LK_HIT   = 4'd7,
        DP_LK_MISS  = 4'd8,
        DP_LV_START = 4'd9,
        DP_LV_SCAN  = 4'd10,
        DP_LV_END   = 4'd11,
        DP_LV_RD    = 4'd12,
        DP_LV_SET   = 4'd13,
        DP_EMIT     = 4'd14
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    scope_zero;
        logic    temps_empty;
        logic    lk_hit;
        logic    lk_done;
        logic    scan_done;
        logic    pop_none;
        logic    res_last;
        logic    out_free;
    } dp_stat_t;

endpackage

[hdl/sst_dp.sv]
`timescale 1ns / 1ps

module sst_dp
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  item,
    input  logic      result_ready,
    output logic      result_valid,
    output out_item_t result,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat
);

    logic [NAME_W-1:0]  name_mem [TABLE_DEPTH];
    logic [SCOPE_W-1:0] scope_mem [TABLE_DEPTH];

    action_t            action_reg, action_next;
    logic [NAME_W-1:0]  key_reg, key_next;
    logic [CNT_W-1:0]   named_count_reg, named_count_next;
    logic [CNT_W-1:0]   temp_floor_reg, temp_floor_next;
    logic [SCOPE_W-1:0] current_scope_reg, current_scope_next;
    logic [TOTAL_W-1:0] temps_total_reg, temps_total_next;
    logic [SCOPE_W-1:0] closed_reg, closed_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   fin_reg, fin_next;
    logic [CNT_W-1:0]   top_reg, top_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    status_t            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic [SCOPE_W-1:0] res_scope_reg, res_scope_next;
    logic [NAME_W-1:0]  res_name_reg, res_name_next;
    logic               res_last_reg, res_last_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;
    logic [NAME_W-1:0]  rd_name_reg;
    logic [SCOPE_W-1:0] rd_scope_reg;

    logic               name_we;
    logic               scope_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               issue_lk;
    logic               issue_lv;
    logic               has_room;
    logic               scope_match;
    logic               name_match;
    logic [CNT_W-1:0]   ptr_dec;
    logic [CNT_W-1:0]   floor_dec;
    logic [CNT_W-1:0]   depth_cnt;

    assign depth_cnt   = CNT_W'(TABLE_DEPTH);
    assign issue_lk    = ptr_reg < named_count_reg;
    assign issue_lv    = ptr_reg != '0;
    assign has_room    = named_count_reg < temp_floor_reg;
    assign scope_match = rd_scope_reg == closed_reg;
    assign name_match  = rd_name_reg == key_reg;
    assign ptr_dec     = ptr_reg - 1'b1;
    assign floor_dec   = temp_floor_reg - 1'b1;

    always_comb
    begin
        action_next        = action_reg;
        key_next           = key_reg;
        named_count_next   = named_count_reg;
        temp_floor_next    = temp_floor_reg;
        current_scope_next = current_scope_reg;
        temps_total_next   = temps_total_reg;
        closed_next        = closed_reg;
        ptr_next           = ptr_reg;
        fin_next           = fin_reg;
        top_next           = top_reg;
        pend_next          = pend_reg;
        pend_addr_next     = pend_addr_reg;
        res_status_next    = res_status_reg;
        res_addr_next      = res_addr_reg;
        res_scope_next     = res_scope_reg;
        res_name_next      = res_name_reg;
        res_last_next      = res_last_reg;
        out_valid_next     = out_valid_reg;
        out_next           = out_reg;
        name_we            = 1'b0;
        scope_we           = 1'b0;
        wr_addr            = '0;
        rd_en              = 1'b0;
        rd_addr            = '0;

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            DP_LATCH:
            begin
                action_next = action_t'(item.action);
                key_next    = item.name_key;
            end
            DP_SINGLE:
            begin
                res_status_next = ST_OK;
                res_addr_next   = '0;
                res_scope_next  = current_scope_reg;
                res_name_next   = '0;
                res_last_next   = 1'b1;
                case (action_reg) inside
                    ACT_ADD:
                    begin
                        if (has_room)
                        begin
                            name_we          = 1'b1;
                            scope_we         = 1'b1;
                            wr_addr          = named_count_reg[ADDR_W-1:0];
                            named_count_next = named_count_reg + 1'b1;
                            res_addr_next    = named_count_reg[ADDR_W-1:0];
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    ACT_ENTER:
                    begin
                        if (current_scope_reg == SCOPE_MAX)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            current_scope_next = current_scope_reg + 1'b1;
                            res_scope_next     = current_scope_reg + 1'b1;
                        end
                    end
                    ACT_TEMP_ADD:
                    begin
                        if (has_room)
                        begin
                            scope_we        = 1'b1;
                            wr_addr         = floor_dec[ADDR_W-1:0];
                            temp_floor_next = floor_dec;
                            res_addr_next   = floor_dec[ADDR_W-1:0];
                            if (temps_total_reg != TOTAL_MAX)
                            begin
                                temps_total_next = temps_total_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    ACT_LEAVE, ACT_TEMP_FREE, ACT_TEMP_QUERY:
                    begin
                        res_status_next = ST_EMPTY;
                    end
                    ACT_TEMP_FREE_ALL:
                    begin
                        temp_floor_next = depth_cnt;
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            DP_TEMP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = temp_floor_reg[ADDR_W-1:0];
            end
            DP_TEMP_FIN:
            begin
                res_status_next = ST_OK;
                res_addr_next   = temp_floor_reg[ADDR_W-1:0];
                res_scope_next  = rd_scope_reg;
                res_name_next   = '0;
                res_last_next   = 1'b1;
                if (action_reg == ACT_TEMP_FREE)
                begin
                    temp_floor_next = temp_floor_reg + 1'b1;
                end
            end
            DP_LK_START:
            begin
                ptr_next  = '0;
                pend_next = 1'b0;
            end
            DP_LK_STEP:
            begin
                rd_en          = issue_lk;
                rd_addr        = ptr_reg[ADDR_W-1:0];
                pend_next      = issue_lk;
                pend_addr_next = ptr_reg[ADDR_W-1:0];
                if (issue_lk)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            DP_LK_HIT:
            begin
                res_status_next = ST_OK;
                res_addr_next   = pend_addr_reg;
                res_scope_next  = rd_scope_reg;
                res_name_next   = '0;
                res_last_next   = 1'b1;
            end
            DP_LK_MISS:
            begin
                res_status_next = ST_NOT_FOUND;
                res_addr_next   = '0;
                res_scope_next  = current_scope_reg;
                res_name_next   = '0;
                res_last_next   = 1'b1;
            end
            DP_LV_START:
            begin
                ptr_next           = named_count_reg;
                fin_next           = named_count_reg;
                top_next           = named_count_reg;
                pend_next          = 1'b0;
                closed_next        = current_scope_reg;
                current_scope_next = current_scope_reg - 1'b1;
            end
            DP_LV_SCAN:
            begin
                rd_en          = issue_lv;
                rd_addr        = ptr_dec[ADDR_W-1:0];
                pend_next      = issue_lv;
                pend_addr_next = ptr_dec[ADDR_W-1:0];
                if (issue_lv)
                begin
                    ptr_next = ptr_dec;
                end
                if (pend_reg && scope_match)
                begin
                    fin_next = CNT_W'(pend_addr_reg);
                end
            end
            DP_LV_END:
            begin
                named_count_next = fin_reg;
                ptr_next         = top_reg - 1'b1;
                if (fin_reg == top_reg)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = '0;
                    res_scope_next  = current_scope_reg;
                    res_name_next   = '0;
                    res_last_next   = 1'b1;
                end
            end
            DP_LV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = ptr_reg[ADDR_W-1:0];
            end
            DP_LV_SET:
            begin
                res_status_next = ST_OK;
                res_addr_next   = ptr_reg[ADDR_W-1:0];
                res_scope_next  = closed_reg;
                res_name_next   = rd_name_reg;
                res_last_next   = ptr_reg == fin_reg;
                ptr_next        = ptr_dec;
            end
            DP_EMIT:
            begin
                out_valid_next         = 1'b1;
                out_next.status        = res_status_reg;
                out_next.address       = 6'(res_addr_reg);
                out_next.scope_level   = res_scope_reg;
                out_next.removed_name  = res_name_reg;
                out_next.symbol_count  = 7'(named_count_reg);
                out_next.temp_count    = 7'(depth_cnt - temp_floor_reg);
                out_next.temps_created = temps_total_reg;
                out_next.last          = res_last_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
        begin
            name_mem[wr_addr] <= key_reg;
        end
        if (scope_we)
        begin
            scope_mem[wr_addr] <= current_scope_reg;
        end
        if (rd_en)
        begin
            rd_name_reg  <= name_mem[rd_addr];
            rd_scope_reg <= scope_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            named_count_reg   <= '0;
            temp_floor_reg    <= CNT_W'(TABLE_DEPTH);
            current_scope_reg <= '0;
            temps_total_reg   <= '0;
            pend_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            named_count_reg   <= named_count_next;
            temp_floor_reg    <= temp_floor_next;
            current_scope_reg <= current_scope_next;
            temps_total_reg   <= temps_total_next;
            pend_reg          <= pend_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg     <= action_next;
        key_reg        <= key_next;
        closed_reg     <= closed_next;
        ptr_reg        <= ptr_next;
        fin_reg        <= fin_next;
        top_reg        <= top_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_scope_reg  <= res_scope_next;
        res_name_reg   <= res_name_next;
        res_last_reg   <= res_last_next;
        out_reg        <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        stat.action      = action_reg;
        stat.scope_zero  = current_scope_reg == '0;
        stat.temps_empty = temp_floor_reg == depth_cnt;
        stat.lk_hit      = pend_reg && name_match;
        stat.lk_done     = !pend_reg && !issue_lk;
        stat.scan_done   = (pend_reg && !scope_match) || (!pend_reg && !issue_lv);
        stat.pop_none    = fin_reg == top_reg;
        stat.res_last    = res_last_reg;
        stat.out_free    = !out_valid_reg || result_ready;
    end

    a_regions_apart: assert property (@(posedge clk) disable iff (!rst_n)
        named_count_reg <= temp_floor_reg && temp_floor_reg <= depth_cnt)
        else $error("named region overlaps temporary region");

    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_LV_SCAN |-> fin_reg <= top_reg && ptr_reg <= top_reg)
        else $error("scope scan moved above the named region");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_EMIT |=> result_valid && result.last == $past(res_last_reg))
        else $error("result register not loaded on emit");

endmodule

[hdl/sst_ctrl.sv]
`timescale 1ns / 1ps

module sst_ctrl
    import sst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_EXEC     = 9'b000000010,
        S_TEMP_FIN = 9'b000000100,
        S_LK       = 9'b000001000,
        S_LV_SCAN  = 9'b000010000,
        S_LV_RD    = 9'b000100000,
        S_LV_SET   = 9'b001000000,
        S_EMIT     = 9'b010000000,
        S_TEMP_RD  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign item_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = DP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.action) inside
                    ACT_LOOKUP:
                    begin
                        cmd.op     = DP_LK_START;
                        state_next = S_LK;
                    end
                    ACT_LEAVE:
                    begin
                        if (stat.scope_zero)
                        begin
                            cmd.op     = DP_SINGLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.op     = DP_LV_START;
                            state_next = S_LV_SCAN;
                        end
                    end
                    ACT_TEMP_FREE, ACT_TEMP_QUERY:
                    begin
                        if (stat.temps_empty)
                        begin
                            cmd.op     = DP_SINGLE;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.op     = DP_TEMP_RD;
                            state_next = S_TEMP_FIN;
                        end
                    end
                    default:
                    begin
                        cmd.op     = DP_SINGLE;
                        state_next = S_EMIT;
                    end
                endcase
            end
            S_TEMP_RD:
            begin
                cmd.op     = DP_TEMP_RD;
                state_next = S_TEMP_FIN;
            end
            S_TEMP_FIN:
            begin
                cmd.op     = DP_TEMP_FIN;
                state_next = S_EMIT;
            end
            S_LK:
            begin
                if (stat.lk_hit)
                begin
                    cmd.op     = DP_LK_HIT;
                    state_next = S_EMIT;
                end
                else if (stat.lk_done)
                begin
                    cmd.op     = DP_LK_MISS;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.op = DP_LK_STEP;
                end
            end
            S_LV_SCAN:
            begin
                if (stat.scan_done)
                begin
                    cmd.op     = DP_LV_END;
                    state_next = stat.pop_none ? S_EMIT : S_LV_RD;
                end
                else
                begin
                    cmd.op = DP_LV_SCAN;
                end
            end
            S_LV_RD:
            begin
                cmd.op     = DP_LV_RD;
                state_next = S_LV_SET;
            end
            S_LV_SET:
            begin
                cmd.op     = DP_LV_SET;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_EMIT;
                    state_next = stat.res_last ? S_IDLE : S_LV_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> state_reg == S_EXEC)
        else $error("transfer accepted without starting execution");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && !stat.out_free |=> state_reg == S_EMIT)
        else $error("left emit state while the result register was busy");

endmodule

[hdl/scoped_symbol_table.sv]
`timescale 1ns / 1ps
// Steps: add, enter, add temp, free all, leave at scope zero, and free last or query with no
// temporaries are done in a single step and then emitted; free last and query of a live
// temporary first read the temporary's slot; a lookup reads entries from 0 upward until a
// hit or the named count. Throughput: one at a time; a lookup walks the single memory port one entry per cycle.
// A leave scans down the named region and then reads, sets and emits each pop in turn. Reset (rst_n, asynchronous,
// active low) empties both regions and clears scope and temp total; entries stay unwritten.

module scoped_symbol_table
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sst_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    sst_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .stat         (stat)
    );

endmodule
